### sv/framed_rgb_command_parser_core_macros.svh
// Assertion macros shared by the framed RGB command parser RTL.
`ifndef FRAMED_RGB_COMMAND_PARSER_CORE_MACROS_SVH
`define FRAMED_RGB_COMMAND_PARSER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FRGB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FRGB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/frgb_pkg.sv
// Constants and helper functions for the framed RGB command parser.
`default_nettype none

package frgb_pkg;

  localparam int MAX_KEPT_CHARS_DEFAULT = 13;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_OPEN  = 8'h5B;
  localparam logic [7:0] CHAR_CLOSE = 8'h5D;

  localparam logic [1:0] PHASE_SKIP   = 2'd0;
  localparam logic [1:0] PHASE_NUMBER = 2'd1;
  localparam logic [1:0] PHASE_DONE   = 2'd2;

  localparam logic [1:0] FIELD_NONE = 2'd3;
  localparam logic [8:0] MAG_SAT    = 9'd256;
  localparam logic [7:0] VALUE_MAX  = 8'd255;
  localparam logic [6:0] PERCENT_MAX = 7'd100;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // floor(v * 100 / 255) via floor(x / 255) = (x + 1 + (x >> 8)) >> 8
  function automatic logic [6:0] percent(input logic [7:0] v);
    logic [14:0] x;
    logic [15:0] s;
    x = 15'(v) * 15'd100;
    s = 16'(x) + 16'd1 + 16'(x[14:8]);
    return s[14:8];
  endfunction

endpackage

`default_nettype wire

### sv/framed_rgb_command_parser_core.sv
// Framed RGB command parser: byte-wise frame scan, token parse and result register.
// A closing ']' passes from the input register to the result register, where its result shows.
// Throughput: one byte per cycle; a ']' waits only while a stalled result is held.
// Reset (rst, synchronous): leave the frame, clear the parse state, drop pending bytes
// and any result not yet taken.
`default_nettype none

module framed_rgb_command_parser_core #(
  parameter int MAX_KEPT_CHARS = frgb_pkg::MAX_KEPT_CHARS_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rx_valid,
  output logic            rx_stall,
  input  wire logic [7:0] rx_byte,
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic [7:0]      red,
  output logic [7:0]      green,
  output logic [7:0]      blue,
  output logic [6:0]      red_percent,
  output logic [6:0]      green_percent,
  output logic [6:0]      blue_percent
);

  localparam int KEPT_W = $clog2(MAX_KEPT_CHARS + 1);

  // input register
  logic       byte_valid;
  logic [7:0] byte_data;

  // parse state
  logic              in_frame;
  logic [KEPT_W-1:0] kept_count;
  logic [1:0]        field_number;
  logic              token_open;
  logic [1:0]        number_phase;
  logic              is_negative;
  logic [8:0]        magnitude;
  logic [7:0]        field_values [3];

  logic              in_frame_next;
  logic [KEPT_W-1:0] kept_count_next;
  logic [1:0]        field_number_next;
  logic              token_open_next;
  logic [1:0]        number_phase_next;
  logic              is_negative_next;
  logic [8:0]        magnitude_next;
  logic [7:0]        field_values_next [3];

  logic       emit;
  logic       out_free;
  logic       advance;
  logic       commit_ok;
  logic [7:0] commit_val;
  logic       take_digit;
  logic [11:0] mag_prod;
  logic [7:0] emit_vals [3];

  assign out_free = !result_valid || !result_stall;
  assign advance  = byte_valid && (!emit || out_free);
  assign rx_stall = byte_valid && !advance;

  assign commit_ok  = token_open && (field_number != frgb_pkg::FIELD_NONE);
  assign commit_val = is_negative ? 8'd0 :
                      (magnitude > 9'(frgb_pkg::VALUE_MAX)) ? frgb_pkg::VALUE_MAX :
                      magnitude[7:0];
  assign mag_prod   = 12'(magnitude) * 12'd10 + 12'(byte_data[3:0]);

  always_comb begin
    in_frame_next     = in_frame;
    kept_count_next   = kept_count;
    field_number_next = field_number;
    token_open_next   = token_open;
    number_phase_next = number_phase;
    is_negative_next  = is_negative;
    magnitude_next    = magnitude;
    field_values_next = field_values;
    emit              = 1'b0;
    take_digit        = 1'b0;
    for (int k = 0; k < 3; k++) begin
      emit_vals[k] = (commit_ok && field_number == 2'(k)) ? commit_val : field_values[k];
    end

    if (!in_frame) begin
      if (byte_data == frgb_pkg::CHAR_OPEN) begin
        in_frame_next     = 1'b1;
        kept_count_next   = '0;
        field_number_next = 2'd0;
        token_open_next   = 1'b0;
        number_phase_next = frgb_pkg::PHASE_SKIP;
        is_negative_next  = 1'b0;
        magnitude_next    = '0;
        for (int k = 0; k < 3; k++) field_values_next[k] = '0;
      end
    end else if (byte_data == frgb_pkg::CHAR_CLOSE) begin
      emit              = 1'b1;
      in_frame_next     = 1'b0;
      kept_count_next   = '0;
      field_number_next = 2'd0;
      token_open_next   = 1'b0;
      number_phase_next = frgb_pkg::PHASE_SKIP;
      is_negative_next  = 1'b0;
      magnitude_next    = '0;
      for (int k = 0; k < 3; k++) field_values_next[k] = '0;
    end else if (kept_count < KEPT_W'(MAX_KEPT_CHARS)) begin
      kept_count_next = kept_count + 1'b1;
      if (field_number != frgb_pkg::FIELD_NONE) begin
        if (byte_data == frgb_pkg::CHAR_NUL || byte_data == frgb_pkg::CHAR_COMMA) begin
          if (token_open) begin
            field_values_next = emit_vals;
            field_number_next = field_number + 1'b1;
            token_open_next   = 1'b0;
            number_phase_next = frgb_pkg::PHASE_SKIP;
            is_negative_next  = 1'b0;
            magnitude_next    = '0;
          end
          if (byte_data == frgb_pkg::CHAR_NUL) begin
            field_number_next = frgb_pkg::FIELD_NONE;
          end
        end else begin
          token_open_next = 1'b1;
          if (number_phase == frgb_pkg::PHASE_SKIP) begin
            if (!frgb_pkg::is_space(byte_data)) begin
              number_phase_next = frgb_pkg::PHASE_NUMBER;
              if (byte_data == frgb_pkg::CHAR_MINUS) begin
                is_negative_next = 1'b1;
              end else if (byte_data != frgb_pkg::CHAR_PLUS) begin
                take_digit = 1'b1;
              end
            end
          end else if (number_phase == frgb_pkg::PHASE_NUMBER) begin
            take_digit = 1'b1;
          end
          if (take_digit) begin
            if (frgb_pkg::is_digit(byte_data)) begin
              magnitude_next = (mag_prod > 12'(frgb_pkg::MAG_SAT)) ? frgb_pkg::MAG_SAT :
                               mag_prod[8:0];
            end else begin
              number_phase_next = frgb_pkg::PHASE_DONE;
            end
          end
        end
      end
    end
  end

  // input register: take a request whenever the register is empty or the held byte moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!rx_stall) begin
      byte_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rx_stall && rx_valid) begin
      byte_data <= rx_byte;
    end
  end

  // parse state: advance on each processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      kept_count   <= '0;
      field_number <= 2'd0;
      token_open   <= 1'b0;
      number_phase <= frgb_pkg::PHASE_SKIP;
      is_negative  <= 1'b0;
      magnitude    <= '0;
      for (int k = 0; k < 3; k++) field_values[k] <= '0;
    end else if (advance) begin
      in_frame     <= in_frame_next;
      kept_count   <= kept_count_next;
      field_number <= field_number_next;
      token_open   <= token_open_next;
      number_phase <= number_phase_next;
      is_negative  <= is_negative_next;
      magnitude    <= magnitude_next;
      field_values <= field_values_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      red           <= emit_vals[0];
      green         <= emit_vals[1];
      blue          <= emit_vals[2];
      red_percent   <= frgb_pkg::percent(emit_vals[0]);
      green_percent <= frgb_pkg::percent(emit_vals[1]);
      blue_percent  <= frgb_pkg::percent(emit_vals[2]);
    end
  end

`include "framed_rgb_command_parser_core_macros.svh"

  `FRGB_ASSERT_NEXT(a_close_ends_frame, advance && emit, !in_frame && result_valid, "close did not end frame")
  `FRGB_ASSERT_NOW(a_idle_state_clear, !in_frame, kept_count == '0 && field_number == 2'd0, "state not clear outside frame")
  `FRGB_ASSERT_NOW(a_kept_bound, 1'b1, kept_count <= KEPT_W'(MAX_KEPT_CHARS), "kept count overflow")
  `FRGB_ASSERT_NOW(a_percent_range, result_valid, red_percent <= frgb_pkg::PERCENT_MAX && green_percent <= frgb_pkg::PERCENT_MAX && blue_percent <= frgb_pkg::PERCENT_MAX, "percent out of range")

endmodule

`default_nettype wire

### tb/tb_framed_rgb_command_parser_core.sv
// Self-checking testbench for the framed RGB command parser: byte stream in, color results out.
`timescale 1ns / 100ps

module tb_framed_rgb_command_parser_core;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_BYTES = 950;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [6:0] red_pct;
    logic [6:0] green_pct;
    logic [6:0] blue_pct;
  } color_t;

  class frame_color_board;
    bit          framing;
    int unsigned kept;
    logic [1:0]  field_idx;
    bit          token_started;
    logic [1:0]  phase;
    bit          negative;
    logic [8:0]  mag;
    logic [7:0]  vals[3];
    color_t      want_colors[$];
    int          errors;

    function new();
      framing = 1'b0;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_token();
      token_started = 1'b0;
      phase = frgb_pkg::PHASE_SKIP;
      negative = 1'b0;
      mag = '0;
    endfunction

    function void clear_frame();
      kept = 0;
      field_idx = '0;
      vals[0] = '0;
      vals[1] = '0;
      vals[2] = '0;
      clear_token();
    endfunction

    function void commit_token();
      if (token_started && field_idx != frgb_pkg::FIELD_NONE) begin
        if (negative) vals[field_idx] = '0;
        else if (mag > frgb_pkg::VALUE_MAX) vals[field_idx] = frgb_pkg::VALUE_MAX;
        else vals[field_idx] = mag[7:0];
        field_idx++;
      end
      clear_token();
    endfunction

    function logic [6:0] pct_of(logic [7:0] v);
      return 7'((int'(v) * 100) / 255);
    endfunction

    // Track one accepted request; queue a color when a frame closes.
    function void parse_byte(logic [7:0] c);
      bit     done;
      int     acc;
      color_t col;
      done = 1'b0;
      if (!framing) begin
        if (c == frgb_pkg::CHAR_OPEN) begin
          framing = 1'b1;
          clear_frame();
        end
      end else if (c == frgb_pkg::CHAR_CLOSE) begin
        commit_token();
        col.red = vals[0];
        col.green = vals[1];
        col.blue = vals[2];
        col.red_pct = pct_of(vals[0]);
        col.green_pct = pct_of(vals[1]);
        col.blue_pct = pct_of(vals[2]);
        want_colors.push_back(col);
        framing = 1'b0;
        clear_frame();
      end else if (kept < frgb_pkg::MAX_KEPT_CHARS_DEFAULT) begin
        kept++;
        if (field_idx != frgb_pkg::FIELD_NONE) begin
          if (c == frgb_pkg::CHAR_NUL) begin
            commit_token();
            field_idx = frgb_pkg::FIELD_NONE;
          end else if (c == frgb_pkg::CHAR_COMMA) begin
            if (token_started) commit_token();
          end else begin
            token_started = 1'b1;
            if (phase == frgb_pkg::PHASE_SKIP) begin
              if (c == frgb_pkg::CHAR_SPACE ||
                  (c >= frgb_pkg::CHAR_TAB && c <= frgb_pkg::CHAR_CR)) begin
                done = 1'b1;
              end else begin
                phase = frgb_pkg::PHASE_NUMBER;
                if (c == frgb_pkg::CHAR_MINUS) begin
                  negative = 1'b1;
                  done = 1'b1;
                end else if (c == frgb_pkg::CHAR_PLUS) begin
                  done = 1'b1;
                end
              end
            end
            if (!done && phase == frgb_pkg::PHASE_NUMBER) begin
              if (c >= frgb_pkg::CHAR_ZERO && c <= frgb_pkg::CHAR_NINE) begin
                acc = int'(mag) * 10 + int'(c - frgb_pkg::CHAR_ZERO);
                mag = (acc > int'(frgb_pkg::MAG_SAT)) ? frgb_pkg::MAG_SAT : 9'(acc);
              end else begin
                phase = frgb_pkg::PHASE_DONE;
              end
            end
          end
        end
      end
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("%t: %s", $realtime, msg);
    endfunction

    function void check_color(color_t got);
      color_t want;
      if (want_colors.size() == 0) begin
        note_error($sformatf("unexpected color %0d,%0d,%0d", got.red, got.green, got.blue));
      end else begin
        want = want_colors.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.red_pct !== want.red_pct || got.green_pct !== want.green_pct ||
            got.blue_pct !== want.blue_pct)
          note_error($sformatf("color mismatch: expected %0d,%0d,%0d (%0d,%0d,%0d) got %0d,%0d,%0d (%0d,%0d,%0d)",
                               want.red, want.green, want.blue,
                               want.red_pct, want.green_pct, want.blue_pct,
                               got.red, got.green, got.blue,
                               got.red_pct, got.green_pct, got.blue_pct));
      end
    endfunction

    function int pending();
      return want_colors.size();
    endfunction
  endclass

  logic       clk;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_stall;
  logic [7:0] rx_byte = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [6:0] red_percent;
  logic [6:0] green_percent;
  logic [6:0] blue_percent;

  frame_color_board board = new();
  logic [7:0]       burst_q[$];
  int               calm_left = 0;
  int               stall_hold = 0;
  int               idle_cycles = 0;

  framed_rgb_command_parser_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .rx_valid      (rx_valid),
    .rx_stall      (rx_stall),
    .rx_byte       (rx_byte),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .red_percent   (red_percent),
    .green_percent (green_percent),
    .blue_percent  (blue_percent)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_byte(logic [7:0] b);
    int gap;
    int pick;
    gap = 0;
    if (calm_left > 0) begin
      calm_left--;
    end else begin
      pick = $urandom_range(0, 19);
      if (pick == 0) calm_left = $urandom_range(10, 40);
      else if (pick >= 12 && pick < 19) gap = $urandom_range(1, 3);
      else if (pick == 19) gap = $urandom_range(5, 30);
    end
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    board.parse_byte(b);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] any_but_close();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == frgb_pkg::CHAR_CLOSE);
    return b;
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      board.check_color({red, green, blue, red_percent, green_percent, blue_percent});
    if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      case ($urandom_range(0, 9)) inside
        [0:4]: begin
          result_stall <= 1'b0;
          stall_hold = $urandom_range(1, 20);
        end
        9: begin
          result_stall <= 1'b1;
          stall_hold = $urandom_range(10, 40);
        end
        default: begin
          result_stall <= 1'b1;
          stall_hold = $urandom_range(0, 2);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_valid && !rx_stall) || (result_valid && !result_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int pick;
    int ntok;
    int frame_bytes;
    frame_bytes = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_text("]");
    send_text("[255,,0]");
    send_text("[ -7,+300,\t9,4]");
    send_text("[[1");
    send_byte(frgb_pkg::CHAR_NUL);
    send_text("2]");
    send_text("[]");

    while (frame_bytes < RANDOM_BYTES) begin
      burst_q.delete();
      pick = $urandom_range(0, 15);
      if (pick < 12) begin
        burst_q.push_back(frgb_pkg::CHAR_OPEN);
        if ($urandom_range(0, 7) == 0)
          repeat ($urandom_range(1, 2)) burst_q.push_back(frgb_pkg::CHAR_COMMA);
        ntok = ($urandom_range(0, 9) < 7) ? 3 : $urandom_range(0, 5);
        for (int t = 0; t < ntok; t++) begin
          if (t > 0)
            repeat (($urandom_range(0, 5) == 0) ? $urandom_range(2, 3) : 1)
              burst_q.push_back(frgb_pkg::CHAR_COMMA);
          if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2))
              burst_q.push_back(($urandom_range(0, 5) == 0) ? frgb_pkg::CHAR_SPACE :
                                8'(frgb_pkg::CHAR_TAB + $urandom_range(0, 4)));
          case ($urandom_range(0, 7))
            0: burst_q.push_back(frgb_pkg::CHAR_MINUS);
            1: burst_q.push_back(frgb_pkg::CHAR_PLUS);
            default: ;
          endcase
          repeat (($urandom_range(0, 9) != 0) ? $urandom_range(1, 3) : $urandom_range(0, 7))
            burst_q.push_back(8'(frgb_pkg::CHAR_ZERO + $urandom_range(0, 9)));
          if ($urandom_range(0, 9) == 0) burst_q.push_back(any_but_close());
        end
        if ($urandom_range(0, 11) == 0)
          burst_q.insert($urandom_range(1, burst_q.size()), frgb_pkg::CHAR_NUL);
        burst_q.push_back(frgb_pkg::CHAR_CLOSE);
        frame_bytes += burst_q.size();
      end else if (pick < 14) begin
        repeat ($urandom_range(1, 4)) burst_q.push_back(8'($urandom_range(0, 255)));
      end else if (pick == 14) begin
        burst_q.push_back(frgb_pkg::CHAR_OPEN);
        repeat ($urandom_range(1, 16)) burst_q.push_back(any_but_close());
        burst_q.push_back(frgb_pkg::CHAR_CLOSE);
        frame_bytes += burst_q.size();
      end else begin
        burst_q.push_back(frgb_pkg::CHAR_CLOSE);
      end
      foreach (burst_q[i]) send_byte(burst_q[i]);
    end
    rx_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/frgb_pkg.sv
sv/framed_rgb_command_parser_core.sv
tb/tb_framed_rgb_command_parser_core.sv
